>>> src/ptik_pkg.sv
// shared types, constants and helpers of the priority table
`default_nettype none
package ptik_pkg;

	localparam int ENTRIES    = 256;
	localparam int STAMP_BITS = 32;
	localparam int ADDR_W     = $clog2(ENTRIES);
	localparam int FUNC_W     = 2;
	localparam int ID_W       = 8;
	localparam int LVL_W      = 7;
	localparam int LEVEL_MAX  = 100;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT   = 2'd0,
		FN_INCREASE = 2'd1,
		FN_REMOVE   = 2'd2,
		FN_QUERY    = 2'd3
	} func_t;

	typedef struct packed {
		logic [LVL_W-1:0]      level;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	// what the comparator sees: scanned entry against the best so far
	typedef struct packed {
		entry_t cand;
		entry_t best;
		logic   has_best;
	} cmp_req_t;

	function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W:0] v);
		logic [LVL_W:0] lim;
		lim = (LVL_W+1)'(LEVEL_MAX);
		return (v > lim) ? lim[LVL_W-1:0] : v[LVL_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> src/ptik_in_if.sv
// command channel: function, entry index and amount
`default_nettype none
interface ptik_in_if
	import ptik_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   entry_id;
	logic [LVL_W-1:0]  amount;

	modport source (output valid, output func, output entry_id, output amount, input ready);
	modport sink   (input valid, input func, input entry_id, input amount, output ready);
endinterface
`default_nettype wire

>>> src/ptik_out_if.sv
// result channel: winning index and empty flag
`default_nettype none
interface ptik_out_if
	import ptik_pkg::*;
	;
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] winner_id;
	logic            table_empty;

	modport source (output valid, output winner_id, output table_empty, input ready);
	modport sink   (input valid, input winner_id, input table_empty, output ready);
endinterface
`default_nettype wire

>>> src/ptik_cmp.sv
// shared priority comparator used by the query scan
`default_nettype none
module ptik_cmp
	import ptik_pkg::*;
(
	input  cmp_req_t req,
	output logic     beats
);
	logic lvl_gt;
	logic lvl_eq;
	logic stamp_lt;

	assign lvl_gt   = req.cand.level > req.best.level;
	assign lvl_eq   = req.cand.level == req.best.level;
	assign stamp_lt = req.cand.stamp < req.best.stamp;

	// strict win only, so equal level and stamp keep the lower index
	assign beats = !req.has_best || lvl_gt || (lvl_eq && stamp_lt);
endmodule
`default_nettype wire

>>> src/priority_table_with_increase_key.sv
// top level of the indexed max-priority table with increase-key
// The table holds ENTRIES entries, each a valid mark (flip-flops, cleared by
// reset) and a level/stamp word in a table memory with one write port and a
// registered read port. Insert and remove complete when accepted; increase
// reads the stored level, which comes back from the registered memory read
// in the cycle after the address goes out, and writes the raised level back
// in that cycle. A query reads one entry at a time through the single read
// port, judges each with a single shared comparator against the best so far,
// and then loads the result register. No command is taken while an increase
// or a query is in progress. The result register lets non-query commands go
// on while a finished result waits; a second query waits at its end until
// the earlier result has been taken. No clearing pass is needed after reset.
`default_nettype none
module priority_table_with_increase_key
	import ptik_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ptik_in_if.sink   cmd,
	ptik_out_if.source rsp
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INC,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [STAMP_BITS-1:0] arrival_q;

	// table memory, level and stamp per entry
	entry_t                mem_q [ENTRIES];
	entry_t                rd_q;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_wa;
	entry_t                mem_wd;
	logic [ADDR_W-1:0]     mem_ra;

	// increase read-modify-write
	logic [ADDR_W-1:0]     inc_addr_q;
	logic [LVL_W-1:0]      inc_amt_q;

	// query scan
	logic [ADDR_W:0]       scan_cnt_q;
	logic                  cand_vld_s1;
	logic [ADDR_W-1:0]     cand_idx_s1;
	logic                  found_q;
	entry_t                best_q;
	logic [ADDR_W-1:0]     best_idx_q;
	cmp_req_t              cmp_req;
	logic                  cmp_beats;

	// result register
	logic                  rsp_vld_q;
	logic [ID_W-1:0]       winner_q;
	logic                  empty_q;
	logic                  rsp_load;

	logic                  acc;
	logic                  id_ok;
	logic [ADDR_W-1:0]     cmd_addr;
	func_t                 cmd_func;

	assign cmd.ready       = (state_q == ST_IDLE);
	assign acc             = cmd.valid && cmd.ready;
	assign cmd_func        = func_t'(cmd.func);
	assign id_ok           = 32'(cmd.entry_id) < 32'(ENTRIES);
	assign cmd_addr        = ADDR_W'(cmd.entry_id);

	assign rsp.valid       = rsp_vld_q;
	assign rsp.winner_id   = winner_q;
	assign rsp.table_empty = empty_q;

	// finished scan moves into the result register once it is free or being taken
	assign rsp_load        = (state_q == ST_FINISH) && (!rsp_vld_q || rsp.ready);

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cmd_addr;
		mem_wd = '{level: clamp_level({1'b0, cmd.amount}), stamp: arrival_q};
		mem_ra = cmd_addr;
		unique case (state_q)
			ST_IDLE: begin
				mem_we = acc && id_ok && (cmd_func == FN_INSERT);
			end
			ST_INC: begin
				// write back the raised level, stamp unchanged
				mem_we = 1'b1;
				mem_wa = inc_addr_q;
				mem_wd = '{level: clamp_level({1'b0, rd_q.level} + {1'b0, inc_amt_q}),
					stamp: rd_q.stamp};
			end
			ST_SCAN: begin
				mem_ra = scan_cnt_q[ADDR_W-1:0];
			end
			ST_FINISH: begin
				mem_ra = cmd_addr;
			end
			default: begin
				mem_ra = cmd_addr;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	// scanned entry against the best so far
	assign cmp_req = '{cand: rd_q, best: best_q, has_best: found_q};

	ptik_cmp u_cmp (
		.req   (cmp_req),
		.beats (cmp_beats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			arrival_q   <= '0;
			scan_cnt_q  <= '0;
			cand_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (rsp_vld_q && rsp.ready && !rsp_load) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (cmd_func)
							FN_INSERT: begin
								if (id_ok) begin
									valid_q[cmd_addr] <= 1'b1;
									// counter sticks at its maximum
									if (arrival_q != '1) begin
										arrival_q <= arrival_q + 1'b1;
									end
								end
							end
							FN_INCREASE: begin
								// absent entries are left alone
								if (id_ok && valid_q[cmd_addr]) begin
									inc_addr_q <= cmd_addr;
									inc_amt_q  <= cmd.amount;
									state_q    <= ST_INC;
								end
							end
							FN_REMOVE: begin
								if (id_ok) begin
									valid_q[cmd_addr] <= 1'b0;
								end
							end
							FN_QUERY: begin
								scan_cnt_q  <= '0;
								cand_vld_s1 <= 1'b0;
								found_q     <= 1'b0;
								state_q     <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INC: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// compare the entry read last cycle
					if (cand_vld_s1 && cmp_beats) begin
						best_q     <= rd_q;
						best_idx_q <= cand_idx_s1;
						found_q    <= 1'b1;
					end
					// issue the next read, or drain after the last entry
					if (scan_cnt_q < (ADDR_W+1)'(ENTRIES)) begin
						cand_vld_s1 <= valid_q[scan_cnt_q[ADDR_W-1:0]];
						cand_idx_s1 <= scan_cnt_q[ADDR_W-1:0];
						scan_cnt_q  <= scan_cnt_q + 1'b1;
					end else begin
						cand_vld_s1 <= 1'b0;
						state_q     <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the result register is free or being taken
					if (rsp_load) begin
						rsp_vld_q <= 1'b1;
						winner_q  <= found_q ? ID_W'(best_idx_q) : '0;
						empty_q   <= !found_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// an accepted query always starts a scan from the first entry
	a_query_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd_func == FN_QUERY) |=> (state_q == ST_SCAN && scan_cnt_q == '0))
		else $error("query did not start a scan");

	// an empty table reports index zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && empty_q) |-> (winner_q == '0))
		else $error("empty result with nonzero winner");

	// the table is never written during a scan
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_SCAN))
		else $error("table write during scan");

	// arrival stamps never go backward
	a_arrival_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (arrival_q >= $past(arrival_q)))
		else $error("arrival counter decreased");

endmodule
`default_nettype wire
